// ----- sv/wcs_pkg.sv -----
// shared types and constants for the weighted client selector
// no dependencies; all other files use this package by scoped names
package wcs_pkg;

  localparam int MAX_CLIENTS   = 8;
  localparam int HISTORY_DEPTH = 16;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int CLIENT_W = 3;
  localparam int DUR_W    = 24;
  localparam int TIME_W   = 32;
  localparam int CC_W     = 4;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  // derived widths
  localparam int IDX_W    = $clog2(MAX_CLIENTS);
  localparam int NUM_W    = $clog2(MAX_CLIENTS + 1);
  localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int HPOS_W   = $clog2(HISTORY_DEPTH);
  localparam int WEIGHT_W = CNT_W + DUR_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SELECT  = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_UPDATE  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIENT_COUNT = 1'b0,
    REG_RETRY_WAIT   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN
  } state_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic              upd;
    logic              rel;
    logic [CLIENT_W-1:0] client;
    logic              avail;
    logic [DUR_W-1:0]  dur;
    logic [TIME_W-1:0] tried;
    logic              grant;
    logic [IDX_W-1:0]  grant_idx;
    logic [IDX_W-1:0]  dec_idx;
  } cell_cmd_t;

  // scan context; now and start_pos are held while a scan runs, n and retry_wait follow the config registers
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] retry_wait;
    logic [NUM_W-1:0]  n;
    logic [NUM_W-1:0]  start_pos;
  } scan_ctx_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                found;
    logic [WEIGHT_W-1:0] best_w;
    logic [IDX_W-1:0]    best_idx;
    logic                hi_found;
    logic [IDX_W-1:0]    hi_idx;
    logic                lo_found;
    logic [IDX_W-1:0]    lo_idx;
  } scan_tok_t;

endpackage

// ----- sv/weighted_client_selector_unit.sv -----
// top level of the weighted client selector: sequencer, config registers,
// chain of client cells and grant ring; uses wcs_pkg, wcs_cell, wcs_history
//
// Use: an item is taken when start is high and busy is low. Its result
// appears on granted, chosen and from_fallback for one cycle with done high.
// Release and status-update items act at the transfer edge; they and
// reserved codes give an all-zero result in the next cycle and busy stays
// low, so they may come back to back. A select raises busy. It first reduces
// the round-robin start (last grant + 1) modulo the clients in use by
// repeated subtraction, one step a cycle (r steps, r = (last_grant + 1) / n),
// then sends a token down the row of MAX_CLIENTS cells, one cell a cycle;
// each cell folds in its weight and retry check. Done is registered from the
// token's arrival at the end of the row; busy is low in the done cycle, so
// the next item can be taken at the edge that ends it, where the result
// transfers. The config port writes client_count or retry_wait at any edge
// with cfg_we high. Reset restores all client, ring and config state at
// once; the results cannot be held off by the receiver.
module weighted_client_selector_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic [wcs_pkg::ACTION_W-1:0]   action,
  input  logic [wcs_pkg::CLIENT_W-1:0]   client,
  input  logic                           available,
  input  logic [wcs_pkg::DUR_W-1:0]      avg_duration,
  input  logic [wcs_pkg::TIME_W-1:0]     last_tried,
  input  logic [wcs_pkg::TIME_W-1:0]     now,
  output logic                           granted,
  output logic [wcs_pkg::CLIENT_W-1:0]   chosen,
  output logic                           from_fallback,
  input  logic                           cfg_we,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcs_pkg::CFG_W-1:0]      cfg_data
);

  wcs_pkg::state_t              state;
  wcs_pkg::state_t              state_next;
  logic [wcs_pkg::CC_W-1:0]     client_count;
  logic [wcs_pkg::TIME_W-1:0]   retry_wait;
  logic [wcs_pkg::TIME_W-1:0]   now_q;
  logic [wcs_pkg::NUM_W-1:0]    start_pos;
  logic [wcs_pkg::NUM_W-1:0]    n;

  logic                         accept;
  logic                         prep_done;
  logic                         scan_end;
  logic                         pick_valid;
  logic [wcs_pkg::IDX_W-1:0]    pick_idx;
  logic                         pick_fb;
  logic [wcs_pkg::IDX_W-1:0]    oldest_idx;
  logic [wcs_pkg::IDX_W-1:0]    last_grant;

  wcs_pkg::cell_cmd_t           cmd;
  wcs_pkg::scan_ctx_t           ctx;
  wcs_pkg::scan_tok_t           seed;
  wcs_pkg::scan_tok_t           tok [wcs_pkg::MAX_CLIENTS];
  wcs_pkg::scan_tok_t           tail;

  // clients in use, clamped to 1..MAX_CLIENTS
  always_comb begin
    if (client_count == '0) begin
      n = wcs_pkg::NUM_W'(1);
    end else if (32'(client_count) > wcs_pkg::MAX_CLIENTS) begin
      n = wcs_pkg::NUM_W'(wcs_pkg::MAX_CLIENTS);
    end else begin
      n = wcs_pkg::NUM_W'(client_count);
    end
  end

  assign accept    = start && (state == wcs_pkg::ST_IDLE);
  assign prep_done = (start_pos < n);
  assign tail      = tok[wcs_pkg::MAX_CLIENTS-1];
  assign scan_end  = (state == wcs_pkg::ST_SCAN) && tail.valid;

  // outcome of the scan at the end of the row
  always_comb begin
    pick_valid = 1'b0;
    pick_idx   = '0;
    pick_fb    = 1'b0;
    if (tail.found) begin
      pick_valid = 1'b1;
      pick_idx   = tail.best_idx;
    end else if (tail.hi_found) begin
      pick_valid = 1'b1;
      pick_idx   = tail.hi_idx;
      pick_fb    = 1'b1;
    end else if (tail.lo_found) begin
      pick_valid = 1'b1;
      pick_idx   = tail.lo_idx;
      pick_fb    = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wcs_pkg::ST_IDLE: begin
        if (accept && (action == wcs_pkg::ACT_SELECT)) begin
          state_next = wcs_pkg::ST_PREP;
        end
      end
      wcs_pkg::ST_PREP: begin
        if (prep_done) begin
          state_next = wcs_pkg::ST_SCAN;
        end
      end
      wcs_pkg::ST_SCAN: begin
        if (tail.valid) begin
          state_next = wcs_pkg::ST_IDLE;
        end
      end
      default: state_next = wcs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy          = (state != wcs_pkg::ST_IDLE);
    seed          = '0;
    seed.valid    = (state == wcs_pkg::ST_PREP) && prep_done;
    cmd           = '0;
    cmd.client    = client;
    cmd.avail     = available;
    cmd.dur       = avg_duration;
    cmd.tried     = last_tried;
    cmd.dec_idx   = oldest_idx;
    cmd.grant_idx = pick_idx;
    if (accept) begin
      case (action)
        wcs_pkg::ACT_RELEASE: cmd.rel = 1'b1;
        wcs_pkg::ACT_UPDATE:  cmd.upd = 1'b1;
        default:              cmd.rel = 1'b0;
      endcase
    end
    cmd.grant = scan_end && pick_valid;
  end

  assign ctx.now        = now_q;
  assign ctx.retry_wait = retry_wait;
  assign ctx.n          = n;
  assign ctx.start_pos  = start_pos;

  // state register and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wcs_pkg::ST_IDLE;
      client_count <= wcs_pkg::CC_W'(8);
      retry_wait   <= wcs_pkg::TIME_W'(1000);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          wcs_pkg::REG_CLIENT_COUNT: client_count <= cfg_data[wcs_pkg::CC_W-1:0];
          wcs_pkg::REG_RETRY_WAIT:   retry_wait   <= cfg_data[wcs_pkg::TIME_W-1:0];
          default:                   retry_wait   <= retry_wait;
        endcase
      end
    end
  end

  // captured time and round-robin start reduction
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q     <= now;
      start_pos <= wcs_pkg::NUM_W'(last_grant) + 1'b1;
    end else if ((state == wcs_pkg::ST_PREP) && !prep_done) begin
      start_pos <= start_pos - n;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (action != wcs_pkg::ACT_SELECT)) || scan_end;
    end
  end

  always_ff @(posedge clk) begin
    granted       <= scan_end && pick_valid;
    chosen        <= scan_end ? wcs_pkg::CLIENT_W'(pick_idx) : '0;
    from_fallback <= scan_end && pick_fb;
  end

  // row of client cells
  for (genvar g = 0; g < wcs_pkg::MAX_CLIENTS; g++) begin : g_cell
    wcs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (wcs_pkg::IDX_W'(g)),
      .cmd      (cmd),
      .ctx      (ctx),
      .tok_in   ((g == 0) ? seed : tok[(g == 0) ? 0 : g - 1]),
      .tok_out  (tok[g])
    );
  end

  // grant ring
  wcs_history u_history (
    .clk        (clk),
    .rst        (rst),
    .grant      (cmd.grant),
    .grant_idx  (pick_idx),
    .oldest_idx (oldest_idx),
    .last_grant (last_grant)
  );

endmodule

// ----- sv/wcs_cell.sv -----
// one client cell: holds the client's status and grant count, and folds
// its own candidacy into the scan token on the way past; uses wcs_pkg
module wcs_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wcs_pkg::IDX_W-1:0]    cell_idx,
  input  wcs_pkg::cell_cmd_t           cmd,
  input  wcs_pkg::scan_ctx_t           ctx,
  input  wcs_pkg::scan_tok_t           tok_in,
  output wcs_pkg::scan_tok_t           tok_out
);

  logic                         avail;
  logic                         busy_flag;
  logic [wcs_pkg::DUR_W-1:0]    dur;
  logic [wcs_pkg::TIME_W-1:0]   tried;
  logic [wcs_pkg::CNT_W-1:0]    count;
  logic [wcs_pkg::CNT_W-1:0]    count_next;

  logic                         hit;
  logic                         inc;
  logic                         dec;
  logic                         active;
  logic [wcs_pkg::WEIGHT_W-1:0] weight;
  logic                         take;
  logic                         fb_ok;
  logic [wcs_pkg::TIME_W-1:0]   elapsed;
  wcs_pkg::scan_tok_t           tok_next;

  // command decode
  assign hit = (32'(cmd.client) == 32'(cell_idx));
  assign inc = cmd.grant && (cmd.grant_idx == cell_idx);
  assign dec = cmd.grant && (cmd.dec_idx == cell_idx) && (count != '0);

  always_comb begin
    count_next = count;
    if (dec) begin
      count_next = count_next - 1'b1;
    end
    if (inc) begin
      count_next = count_next + 1'b1;
    end
  end

  // client state
  always_ff @(posedge clk) begin
    if (rst) begin
      avail     <= 1'b0;
      busy_flag <= 1'b0;
      dur       <= wcs_pkg::DUR_W'(1);
      tried     <= '0;
      count     <= (cell_idx == '0) ? wcs_pkg::CNT_W'(wcs_pkg::HISTORY_DEPTH) : '0;
    end else begin
      if (cmd.upd && hit) begin
        avail <= cmd.avail;
        dur   <= cmd.dur;
        tried <= cmd.tried;
      end
      if (cmd.rel && hit) begin
        busy_flag <= 1'b0;
      end
      if (inc) begin
        busy_flag <= 1'b1;
      end
      count <= count_next;
    end
  end

  // candidacy tests for this cell
  assign active  = tok_in.valid && (32'(cell_idx) < 32'(ctx.n));
  assign weight  = wcs_pkg::WEIGHT_W'(count) * wcs_pkg::WEIGHT_W'(dur);
  assign take    = active && avail && !busy_flag && (!tok_in.found || (weight < tok_in.best_w));
  assign elapsed = ctx.now - tried;
  assign fb_ok   = active && !avail && (elapsed > ctx.retry_wait);

  always_comb begin
    tok_next = tok_in;
    if (take) begin
      tok_next.found    = 1'b1;
      tok_next.best_w   = weight;
      tok_next.best_idx = cell_idx;
    end
    // first eligible client at or after the round-robin start
    if (fb_ok && !tok_in.hi_found && (32'(cell_idx) >= 32'(ctx.start_pos))) begin
      tok_next.hi_found = 1'b1;
      tok_next.hi_idx   = cell_idx;
    end
    // first eligible client overall, used when the scan wraps
    if (fb_ok && !tok_in.lo_found) begin
      tok_next.lo_found = 1'b1;
      tok_next.lo_idx   = cell_idx;
    end
  end

  // token register towards the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.found    <= tok_next.found;
    tok_out.best_w   <= tok_next.best_w;
    tok_out.best_idx <= tok_next.best_idx;
    tok_out.hi_found <= tok_next.hi_found;
    tok_out.hi_idx   <= tok_next.hi_idx;
    tok_out.lo_found <= tok_next.lo_found;
    tok_out.lo_idx   <= tok_next.lo_idx;
  end

endmodule

// ----- sv/wcs_history.sv -----
// ring of recent grants with write position and last grant
// uses wcs_pkg; the entry about to be overwritten is shown combinationally
module wcs_history (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      grant,
  input  logic [wcs_pkg::IDX_W-1:0] grant_idx,
  output logic [wcs_pkg::IDX_W-1:0] oldest_idx,
  output logic [wcs_pkg::IDX_W-1:0] last_grant
);

  logic [wcs_pkg::IDX_W-1:0]  ring [wcs_pkg::HISTORY_DEPTH];
  logic [wcs_pkg::HPOS_W-1:0] pos;
  logic [wcs_pkg::HPOS_W-1:0] pos_next;

  assign oldest_idx = ring[pos];
  assign pos_next   = (32'(pos) == wcs_pkg::HISTORY_DEPTH - 1) ? '0 : pos + 1'b1;

  // ring update on each grant
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wcs_pkg::HISTORY_DEPTH; i++) begin
        ring[i] <= '0;
      end
      pos        <= '0;
      last_grant <= '0;
    end else if (grant) begin
      ring[pos]  <= grant_idx;
      pos        <= pos_next;
      last_grant <= grant_idx;
    end
  end

endmodule

// ----- test/weighted_client_selector_unit_tb.sv -----
// testbench for weighted_client_selector_unit: directed and random requests,
// an in-bench predictor of the client choice and a result scoreboard
// depends on wcs_pkg and the weighted_client_selector_unit rtl
module weighted_client_selector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // action code outside the defined set, must be ignored
  localparam logic [wcs_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 146;
  localparam int TAIL_CYCLES = 24;

  typedef struct packed {
    logic [wcs_pkg::ACTION_W-1:0] act;
    logic [wcs_pkg::CLIENT_W-1:0] client;
    logic                         available;
    logic [wcs_pkg::DUR_W-1:0]    dur;
    logic [wcs_pkg::TIME_W-1:0]   tried;
    logic [wcs_pkg::TIME_W-1:0]   now;
  } request_t;

  typedef struct packed {
    logic                         granted;
    logic [wcs_pkg::CLIENT_W-1:0] chosen;
    logic                         from_fallback;
  } grant_t;

  // scoreboard: mirrors the selector state and holds the grants still owed
  class client_pick_board;
    bit                         avail [wcs_pkg::MAX_CLIENTS];
    bit                         engaged [wcs_pkg::MAX_CLIENTS];
    logic [wcs_pkg::DUR_W-1:0]  dur [wcs_pkg::MAX_CLIENTS];
    logic [wcs_pkg::TIME_W-1:0] tried [wcs_pkg::MAX_CLIENTS];
    logic [wcs_pkg::IDX_W-1:0]  ring [wcs_pkg::HISTORY_DEPTH];
    int                         uses [wcs_pkg::MAX_CLIENTS];
    int                         ring_pos;
    int                         last_pick;
    logic [wcs_pkg::CC_W-1:0]   client_count;
    logic [wcs_pkg::TIME_W-1:0] retry_wait;
    grant_t                     pending_grants[$];
    int                         errors;

    function new();
      for (int c = 0; c < wcs_pkg::MAX_CLIENTS; c++) begin
        avail[c] = 0;
        engaged[c] = 0;
        dur[c] = wcs_pkg::DUR_W'(1);
        tried[c] = '0;
        uses[c] = 0;
      end
      for (int h = 0; h < wcs_pkg::HISTORY_DEPTH; h++) ring[h] = '0;
      uses[0] = wcs_pkg::HISTORY_DEPTH;
      ring_pos = 0;
      last_pick = 0;
      client_count = wcs_pkg::CC_W'(8);
      retry_wait = wcs_pkg::TIME_W'(1000);
      errors = 0;
    endfunction

    function void set_reg(wcs_pkg::reg_idx_t idx, logic [wcs_pkg::CFG_W-1:0] data);
      if (idx == wcs_pkg::REG_CLIENT_COUNT) client_count = data[wcs_pkg::CC_W-1:0];
      else retry_wait = data[wcs_pkg::TIME_W-1:0];
    endfunction

    // work out the grant for one accepted request and update the mirror
    function void take_request(request_t r);
      grant_t                     g;
      int                         n;
      int                         pick;
      int                         idx;
      bit                         found;
      longint                     best;
      longint                     w;
      logic [wcs_pkg::TIME_W-1:0] elapsed;
      g = '0;
      found = 0;
      best = 0;
      pick = 0;
      case (r.act)
        wcs_pkg::ACT_RELEASE: engaged[r.client] = 0;
        wcs_pkg::ACT_UPDATE: begin
          avail[r.client] = r.available;
          dur[r.client] = r.dur;
          tried[r.client] = r.tried;
        end
        wcs_pkg::ACT_SELECT: begin
          n = (client_count == 0) ? 1 :
              (client_count > wcs_pkg::MAX_CLIENTS) ? wcs_pkg::MAX_CLIENTS :
              int'(client_count);
          // least weighted idle available client, lowest index on ties
          for (int c = 0; c < n; c++) begin
            if (avail[c] && !engaged[c]) begin
              w = longint'(uses[c]) * longint'(dur[c]);
              if (!found || w < best) begin
                best = w;
                pick = c;
                found = 1;
              end
            end
          end
          // round-robin retry of unavailable clients after the last grant
          if (!found) begin
            for (int k = 0; k < n; k++) begin
              idx = (last_pick + 1 + k) % n;
              elapsed = r.now - tried[idx];
              if (!found && !avail[idx] && elapsed > retry_wait) begin
                pick = idx;
                found = 1;
                g.from_fallback = 1;
              end
            end
          end
          if (found) begin
            if (uses[ring[ring_pos]] > 0) uses[ring[ring_pos]]--;
            ring[ring_pos] = wcs_pkg::IDX_W'(pick);
            uses[pick]++;
            ring_pos = (ring_pos + 1) % wcs_pkg::HISTORY_DEPTH;
            engaged[pick] = 1;
            last_pick = pick;
            g.granted = 1;
            g.chosen = wcs_pkg::CLIENT_W'(pick);
          end
        end
        default: ;
      endcase
      pending_grants.push_back(g);
    endfunction

    // compare one result transfer with the oldest grant owed
    function void match_grant(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t ns: result with none expected, expected none actual granted %0d chosen %0d",
                 $time, got.granted, got.chosen);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      if (got.granted !== want.granted) begin
        $display("%0t ns: granted expected %0d actual %0d",
                 $time, want.granted, got.granted);
        errors++;
      end
      if (got.chosen !== want.chosen) begin
        $display("%0t ns: chosen expected %0d actual %0d",
                 $time, want.chosen, got.chosen);
        errors++;
      end
      if (got.from_fallback !== want.from_fallback) begin
        $display("%0t ns: from_fallback expected %0d actual %0d",
                 $time, want.from_fallback, got.from_fallback);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          done;
  logic [wcs_pkg::ACTION_W-1:0]  action;
  logic [wcs_pkg::CLIENT_W-1:0]  client;
  logic                          available;
  logic [wcs_pkg::DUR_W-1:0]     avg_duration;
  logic [wcs_pkg::TIME_W-1:0]    last_tried;
  logic [wcs_pkg::TIME_W-1:0]    now;
  logic                          granted;
  logic [wcs_pkg::CLIENT_W-1:0]  chosen;
  logic                          from_fallback;
  logic                          cfg_we;
  logic [wcs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wcs_pkg::CFG_W-1:0]     cfg_data;

  client_pick_board board = new();
  logic [wcs_pkg::TIME_W-1:0] wall;
  bit                         calm;

  weighted_client_selector_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .action        (action),
    .client        (client),
    .available     (available),
    .avg_duration  (avg_duration),
    .last_tried    (last_tried),
    .now           (now),
    .granted       (granted),
    .chosen        (chosen),
    .from_fallback (from_fallback),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result transfers are checked at the edge that ends the done cycle
  always @(posedge clk) begin
    if (!rst && done) board.match_grant('{granted, chosen, from_fallback});
  end

  function automatic request_t req(logic [wcs_pkg::ACTION_W-1:0] act, int cli, bit av,
                                   logic [wcs_pkg::DUR_W-1:0] d,
                                   logic [wcs_pkg::TIME_W-1:0] t,
                                   logic [wcs_pkg::TIME_W-1:0] tnow);
    request_t r;
    r.act = act;
    r.client = wcs_pkg::CLIENT_W'(cli);
    r.available = av;
    r.dur = d;
    r.tried = t;
    r.now = tnow;
    return r;
  endfunction

  // random request: time moves on, last-tried sometimes lands around the retry window
  function automatic request_t make_request();
    request_t r;
    int       roll;
    roll = $urandom_range(99);
    r.act = (roll < 42) ? wcs_pkg::ACT_SELECT : (roll < 70) ? wcs_pkg::ACT_RELEASE :
            (roll < 97) ? wcs_pkg::ACT_UPDATE : ACT_RESERVED;
    r.client = wcs_pkg::CLIENT_W'($urandom_range(wcs_pkg::MAX_CLIENTS - 1));
    r.available = ($urandom_range(99) < 60);
    wall = wall + $urandom_range(400);
    r.now = wall;
    case ($urandom_range(9))
      0: r.dur = wcs_pkg::DUR_W'($urandom);
      1: r.dur = '1;
      2: r.dur = '0;
      default: r.dur = wcs_pkg::DUR_W'($urandom_range(1, 20));
    endcase
    case ($urandom_range(3))
      0: r.tried = $urandom;
      1: r.tried = wall - board.retry_wait - 2 + $urandom_range(4);
      default: r.tried = wall - $urandom_range(3000);
    endcase
    return r;
  endfunction

  // present one request from a falling edge and wait for its transfer
  task automatic issue(request_t r);
    start <= 1'b1;
    action <= r.act;
    client <= r.client;
    available <= r.available;
    avg_duration <= r.dur;
    last_tried <= r.tried;
    now <= r.now;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.take_request(r);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    if (!calm && $urandom_range(99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // drop start and wait until every owed grant has come back
  task automatic settle();
    start <= 1'b0;
    while (board.pending_grants.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(wcs_pkg::reg_idx_t idx, logic [wcs_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("[weighted_client_selector_unit] ERROR");
    $finish;
  end

  initial begin
    int                         cc_set [PHASES];
    logic [wcs_pkg::TIME_W-1:0] wait_set [PHASES];
    logic [wcs_pkg::TIME_W-1:0] wall_set [PHASES];
    rst = 1'b1;
    start = 1'b0;
    action = wcs_pkg::ACT_SELECT;
    client = '0;
    available = 1'b0;
    avg_duration = '0;
    last_tried = '0;
    now = '0;
    cfg_we = 1'b0;
    cfg_index = wcs_pkg::REG_CLIENT_COUNT;
    cfg_data = '0;
    calm = 0;
    wall = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pool, retry boundary, weighted picks and ties
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 0));
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 1000));
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 1001));
    issue(req(wcs_pkg::ACT_UPDATE, 0, 1, 0, 0, 0));
    issue(req(wcs_pkg::ACT_UPDATE, 7, 1, '1, '1, '1));
    issue(req(wcs_pkg::ACT_UPDATE, 3, 1, 1, 0, 0));
    repeat (3) issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 2000));
    // fallback ignores the busy flag and wraps after the last grant
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, '1));
    issue(req(wcs_pkg::ACT_RELEASE, 0, 0, 0, 0, 0));
    issue(req(wcs_pkg::ACT_RELEASE, 3, 0, 0, 0, 0));
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 5));
    issue(req(ACT_RESERVED, 7, 1, '1, '1, '1));
    // retry wait measured across the time wrap
    issue(req(wcs_pkg::ACT_UPDATE, 5, 0, 2, 32'hFFFF_FF00, 0));
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 32'h10));
    settle();
    // client count below and above its range
    write_reg(wcs_pkg::REG_CLIENT_COUNT, 0);
    write_reg(wcs_pkg::REG_RETRY_WAIT, 0);
    issue(req(wcs_pkg::ACT_RELEASE, 0, 0, 0, 0, 0));
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 7));
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 8));
    settle();
    write_reg(wcs_pkg::REG_CLIENT_COUNT, 15);
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 9));
    issue(req(wcs_pkg::ACT_RELEASE, 7, 0, 0, 0, 0));
    issue(req(wcs_pkg::ACT_SELECT, 0, 0, 0, 0, 10));

    // random phases over several register settings
    cc_set = '{8, 1, 8, 3, 5, 15, 2};
    wait_set = '{1000, 0, '1, $urandom_range(50, 5000), 200, 0, 1};
    wall_set = '{0, 32'hFFFF_F000, $urandom, 32'h7FFF_FF00, $urandom, 32'hFFFF_FE00, 64};
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(wcs_pkg::REG_CLIENT_COUNT, cc_set[p]);
      write_reg(wcs_pkg::REG_RETRY_WAIT, wait_set[p]);
      wall = wall_set[p];
      // one whole phase runs back to back with no sender gaps
      calm = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pause_sender();
        issue(make_request());
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_grants.size() == 0) begin
      $display("[weighted_client_selector_unit] OK");
    end else begin
      $display("[weighted_client_selector_unit] ERROR");
    end
    $finish;
  end

endmodule
